FILE: rtl/core/zbnf_pkg.sv
// Shared types and constants for the zone bitmap next-fit allocator.
// No dependencies; imported by zbnf_scan and the allocator.
package zbnf_pkg;

    localparam int ZONE_W   = 17;
    localparam int FIRST_W  = 16;
    localparam int STATUS_W = 2;
    localparam int TDATA_W  = 24;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DOUBLE = 2'd3;

    // request kinds (s_tuser)
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // configuration register indexes
    localparam logic REG_FIRST_DATA_ZONE = 1'b0;
    localparam logic REG_ZONE_TOTAL      = 1'b1;

    // which range edges clip the word under test
    typedef struct packed {
        logic use_lo;
        logic use_hi;
    } scan_ctl_t;

endpackage

FILE: rtl/core/zbnf_bitmap.sv
// Bitmap storage: one write port, one read port, registered read data.
// Uses no package items.
module zbnf_bitmap #(
    parameter int WORDS = 1024,
    parameter int WIDTH = 64,
    parameter int WA_W  = 10
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [WA_W-1:0]  wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [WA_W-1:0]  rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [WORDS];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/zbnf_scan.sv
// Scan unit: lowest clear bit of one bitmap word inside a bit window.
// Depends on zbnf_pkg for scan_ctl_t.
module zbnf_scan #(
    parameter int WIDTH = 64,
    parameter int OFF_W = 6
) (
    input  logic [WIDTH-1:0]       word_data,
    input  zbnf_pkg::scan_ctl_t    ctl,
    input  logic [OFF_W-1:0]       lo_off,
    input  logic [OFF_W-1:0]       last_off,
    output logic                   found,
    output logic [OFF_W-1:0]       found_off,
    output logic [WIDTH-1:0]       found_onehot
);
    import zbnf_pkg::*;

    logic [WIDTH-1:0] lo_mask;
    logic [WIDTH-1:0] hi_mask;
    logic [WIDTH-1:0] free_bits;
    logic [WIDTH-1:0] lowest;

    always_comb
    begin
        lo_mask   = ctl.use_lo ? ({WIDTH{1'b1}} << lo_off) : {WIDTH{1'b1}};
        hi_mask   = ctl.use_hi ? ({WIDTH{1'b1}} >> (OFF_W'(WIDTH - 1) - last_off))
                               : {WIDTH{1'b1}};
        free_bits = ~word_data & lo_mask & hi_mask;
        // isolate lowest set bit
        lowest    = free_bits & (~free_bits + WIDTH'(1));
        found     = |free_bits;
        found_off = '0;
        for (int j = 0; j < WIDTH; j++)
        begin
            if (lowest[j])
            begin
                found_off = found_off | OFF_W'(j);
            end
        end
        found_onehot = lowest;
    end

endmodule

FILE: rtl/core/zone_bitmap_next_fit_allocator.sv
// Allocate: states PREP and SETUP, then a read (RD) and an evaluate (EV) state per bitmap
//   word scanned, up to two passes over the in-range words; free: PREP, RD and EV, or PREP
//   alone when the zone is out of range. A result held by m_tready keeps the block busy.
// One request at a time; the word scan through the single-port bitmap read sets the rate.
// After reset a clearing pass writes MAP_BITS/SCAN_WIDTH words, one per cycle, before
// s_tready rises; config writes are taken throughout. Config regs reset to 0 / 65536.
// Depends on zbnf_pkg, zbnf_bitmap, zbnf_scan.
module zone_bitmap_next_fit_allocator #(
    parameter int MAP_BITS   = 65536,
    parameter int SCAN_WIDTH = 64     // power of two
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // request: tdata = zone_number[16:0], zero pad; tuser = mode
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [zbnf_pkg::TDATA_W-1:0] s_tdata,
    input  logic                         s_tuser,
    // result: tdata = granted_zone[16:0], zero pad; tuser = status[1:0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [zbnf_pkg::TDATA_W-1:0] m_tdata,
    output logic [zbnf_pkg::STATUS_W-1:0] m_tuser,
    // configuration writes
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [zbnf_pkg::ZONE_W-1:0]  cfg_data
);
    import zbnf_pkg::*;

    localparam int OFF_W  = $clog2(SCAN_WIDTH);
    localparam int WORDS  = (MAP_BITS + SCAN_WIDTH - 1) / SCAN_WIDTH;
    localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int IDX_W  = $clog2(MAP_BITS);
    localparam int LIM_W  = IDX_W + 1;
    localparam int AW     = (LIM_W + 1 > ZONE_W + 1) ? LIM_W + 1 : ZONE_W + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_SETUP,
        S_RD,
        S_EV
    } state_t;

    state_t                state_reg, state_next;
    logic [FIRST_W-1:0]    first_reg;
    logic [ZONE_W-1:0]     total_reg;
    logic                  mode_reg, mode_next;
    logic [ZONE_W-1:0]     zone_reg, zone_next;
    logic [LIM_W-1:0]      limit_reg, limit_next;
    logic [IDX_W-1:0]      spos_reg, spos_next;
    logic [IDX_W-1:0]      lo_reg, lo_next;
    logic [LIM_W-1:0]      hi_reg, hi_next;
    logic                  phase2_reg, phase2_next;
    logic [WA_W-1:0]       ptr_reg, ptr_next;
    logic [WA_W-1:0]       last_word_reg, last_word_next;
    logic [OFF_W-1:0]      last_off_reg, last_off_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0]    m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0]   m_tuser_reg, m_tuser_next;

    logic                  wr_en;
    logic [SCAN_WIDTH-1:0] wr_data;
    logic [SCAN_WIDTH-1:0] rd_data;
    scan_ctl_t             scan_ctl;
    logic                  scan_found;
    logic [OFF_W-1:0]      scan_off;
    logic [SCAN_WIDTH-1:0] scan_onehot;
    logic                  out_free;
    logic [AW-1:0]         range_aw;
    logic [AW-1:0]         bidx_aw;
    logic [AW-1:0]         found_aw;
    logic [IDX_W-1:0]      hi_m1;
    logic [OFF_W-1:0]      lo_off;

    zbnf_bitmap #(
        .WORDS (WORDS),
        .WIDTH (SCAN_WIDTH),
        .WA_W  (WA_W)
    ) u_bitmap (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ptr_reg),
        .wr_data (wr_data),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    assign lo_off            = lo_reg[OFF_W-1:0];
    assign scan_ctl.use_lo   = (ptr_reg == WA_W'(lo_reg >> OFF_W));
    assign scan_ctl.use_hi   = (ptr_reg == last_word_reg);

    zbnf_scan #(
        .WIDTH (SCAN_WIDTH),
        .OFF_W (OFF_W)
    ) u_scan (
        .word_data    (rd_data),
        .ctl          (scan_ctl),
        .lo_off       (lo_off),
        .last_off     (last_off_reg),
        .found        (scan_found),
        .found_off    (scan_off),
        .found_onehot (scan_onehot)
    );

    // config registers; always ready, host writes only while no request is in flight
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= '0;
            total_reg <= ZONE_W'(65536);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FIRST_DATA_ZONE: first_reg <= cfg_data[FIRST_W-1:0];
                REG_ZONE_TOTAL:      total_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        zone_next      = zone_reg;
        limit_next     = limit_reg;
        spos_next      = spos_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        phase2_next    = phase2_reg;
        ptr_next       = ptr_reg;
        last_word_next = last_word_reg;
        last_off_next  = last_off_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        wr_en          = 1'b0;
        wr_data        = '0;

        // usable bit count: min(total - first, MAP_BITS), zero if range empty
        range_aw = AW'(total_reg) - AW'(first_reg);
        bidx_aw  = AW'(zone_reg) - AW'(first_reg);
        found_aw = (AW'(ptr_reg) << OFF_W) | AW'(scan_off);
        hi_m1    = IDX_W'(hi_reg - LIM_W'(1));

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                ptr_next = ptr_reg + WA_W'(1);
                if (ptr_reg == WA_W'(WORDS - 1))
                begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next = s_tuser;
                    zone_next = s_tdata[ZONE_W-1:0];
                    if (AW'(total_reg) <= AW'(first_reg))
                    begin
                        limit_next = '0;
                    end
                    else if (range_aw > AW'(MAP_BITS))
                    begin
                        limit_next = LIM_W'(MAP_BITS);
                    end
                    else
                    begin
                        limit_next = LIM_W'(range_aw);
                    end
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (mode_reg == MODE_FREE)
                begin
                    if (zone_reg < ZONE_W'(first_reg) || zone_reg >= total_reg ||
                        bidx_aw >= AW'(MAP_BITS))
                    begin
                        if (out_free)
                        begin
                            m_tvalid_next = 1'b1;
                            m_tuser_next  = ST_RANGE;
                            m_tdata_next  = '0;
                            state_next    = S_IDLE;
                        end
                    end
                    else
                    begin
                        lo_next    = IDX_W'(bidx_aw);
                        ptr_next   = WA_W'(bidx_aw >> OFF_W);
                        state_next = S_RD;
                    end
                end
                else
                begin
                    hi_next = limit_reg;
                    if (LIM_W'(spos_reg) < limit_reg)
                    begin
                        lo_next     = spos_reg;
                        phase2_next = 1'b0;
                    end
                    else
                    begin
                        lo_next     = '0;
                        phase2_next = 1'b1;
                    end
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                if (hi_reg == '0)
                begin
                    if (out_free)
                    begin
                        m_tvalid_next = 1'b1;
                        m_tuser_next  = ST_FULL;
                        m_tdata_next  = '0;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    last_word_next = WA_W'(hi_m1 >> OFF_W);
                    last_off_next  = hi_m1[OFF_W-1:0];
                    ptr_next       = WA_W'(lo_reg >> OFF_W);
                    state_next     = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_EV;
            end
            S_EV:
            begin
                if (mode_reg == MODE_FREE)
                begin
                    if (out_free)
                    begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = '0;
                        state_next    = S_IDLE;
                        if (!rd_data[lo_off])
                        begin
                            m_tuser_next = ST_DOUBLE;
                        end
                        else
                        begin
                            m_tuser_next = ST_OK;
                            wr_en        = 1'b1;
                            wr_data      = rd_data & ~(SCAN_WIDTH'(1) << lo_off);
                        end
                    end
                end
                else if (scan_found)
                begin
                    if (out_free)
                    begin
                        wr_en         = 1'b1;
                        wr_data       = rd_data | scan_onehot;
                        spos_next     = IDX_W'(found_aw);
                        m_tvalid_next = 1'b1;
                        m_tuser_next  = ST_OK;
                        m_tdata_next  = TDATA_W'(ZONE_W'(found_aw + AW'(first_reg)));
                        state_next    = S_IDLE;
                    end
                end
                else if (ptr_reg == last_word_reg)
                begin
                    if (!phase2_reg)
                    begin
                        // wrap: rescan bits below the start position
                        phase2_next = 1'b1;
                        lo_next     = '0;
                        hi_next     = LIM_W'(spos_reg);
                        state_next  = S_SETUP;
                    end
                    else if (out_free)
                    begin
                        m_tvalid_next = 1'b1;
                        m_tuser_next  = ST_FULL;
                        m_tdata_next  = '0;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    ptr_next   = ptr_reg + WA_W'(1);
                    state_next = S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            mode_reg      <= MODE_ALLOC;
            zone_reg      <= '0;
            limit_reg     <= '0;
            spos_reg      <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            phase2_reg    <= 1'b0;
            ptr_reg       <= '0;
            last_word_reg <= '0;
            last_off_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
            m_tuser_reg   <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            zone_reg      <= zone_next;
            limit_reg     <= limit_next;
            spos_reg      <= spos_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            phase2_reg    <= phase2_next;
            ptr_reg       <= ptr_next;
            last_word_reg <= last_word_next;
            last_off_reg  <= last_off_next;
            m_tvalid_reg  <= m_tvalid_next;
            m_tdata_reg   <= m_tdata_next;
            m_tuser_reg   <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_grant_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0))
        else $error("nonzero zone on failed request");

    a_spos_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        (AW'(spos_reg) < AW'(MAP_BITS)))
        else $error("search position beyond map");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while busy");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_CLEAR || state_reg == S_EV))
        else $error("bitmap write outside clear or evaluate");

endmodule

FILE: tb/tb_zone_bitmap_next_fit_allocator.sv
// Self-checking bench for zone_bitmap_next_fit_allocator: random bursty request stream,
// stalling result side, config phases between idle points, checked against a next-fit model.
// Depends on zbnf_pkg and the allocator RTL.
module tb_zone_bitmap_next_fit_allocator;

    import zbnf_pkg::*;

    localparam int          MAP_BITS   = 65536;
    localparam int unsigned NO_HIT     = 32'hFFFF_FFFF;
    localparam int          STALL_MAX  = 20000;
    localparam int          RAND_ITEMS = 1850;

    typedef struct packed {
        logic              mode;
        logic [ZONE_W-1:0] zone;
    } zone_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ZONE_W-1:0]   zone;
    } alloc_reply_t;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata   = '0;
    logic                s_tuser   = MODE_ALLOC;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0] m_tuser;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_index = REG_FIRST_DATA_ZONE;
    logic [ZONE_W-1:0]   cfg_data  = '0;

    // mirror of the block state
    bit                  used_map [MAP_BITS];
    int unsigned         scan_pos     = 0;
    logic [FIRST_W-1:0]  first_zone_q = '0;
    logic [ZONE_W-1:0]   zone_total_q = 17'd65536;

    zone_req_t           pending_reqs [$];
    alloc_reply_t        outcomes_due [$];
    int unsigned         held_bits [$];     // bit indexes granted and not yet scheduled to free
    logic [ZONE_W-1:0]   last_freed = '0;

    logic                req_beat = 1'b0;
    int unsigned         tx_gap   = 0;
    int unsigned         tx_burst = 1;
    int unsigned         rx_run   = 0;
    bit                  rx_hold  = 1'b0;
    int unsigned         idle_cycles = 0;
    int unsigned         fail_count  = 0;
    event                monitor_done;

    zone_bitmap_next_fit_allocator #(
        .MAP_BITS   (MAP_BITS),
        .SCAN_WIDTH (64)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ---------------------------------------------------------------- next-fit model
    function automatic int unsigned usable_span();
        int unsigned span;
        span = (zone_total_q > first_zone_q) ? zone_total_q - first_zone_q : 0;
        return (span > MAP_BITS) ? MAP_BITS : span;
    endfunction

    function automatic int unsigned first_clear(int unsigned lo, int unsigned hi);
        for (int unsigned b = lo; b < hi; b++)
        begin
            if (!used_map[b])
                return b;
        end
        return NO_HIT;
    endfunction

    function automatic void next_fit_outcome(logic mode, logic [ZONE_W-1:0] zone);
        alloc_reply_t reply;
        int unsigned  span;
        int unsigned  start;
        int unsigned  hit;
        int unsigned  rel;
        span = usable_span();
        reply.status = ST_OK;
        reply.zone   = '0;
        if (mode == MODE_ALLOC)
        begin
            start = scan_pos;
            hit   = NO_HIT;
            if (start < span)
                hit = first_clear(start, span);
            // wrap: bits below the start position
            if (hit == NO_HIT)
                hit = first_clear(0, (start < span) ? start : span);
            if (hit == NO_HIT)
                reply.status = ST_FULL;
            else
            begin
                used_map[hit] = 1'b1;
                scan_pos      = hit;
                reply.zone    = ZONE_W'(hit + first_zone_q);
                held_bits.push_back(hit);
            end
        end
        else
        begin
            rel = zone - first_zone_q;
            if (zone < first_zone_q || zone >= zone_total_q || rel >= MAP_BITS)
                reply.status = ST_RANGE;
            else if (!used_map[rel])
                reply.status = ST_DOUBLE;
            else
                used_map[rel] = 1'b0;
        end
        outcomes_due.push_back(reply);
    endfunction

    // ---------------------------------------------------------------- request driver
    always @(negedge clk)
    begin : drive_req
        zone_req_t nxt;
        if (!s_tvalid || req_beat)
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                nxt = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.mode;
                s_tdata  <= {{(TDATA_W-ZONE_W){1'b0}}, nxt.zone};
                if (tx_burst > 1)
                    tx_burst--;
                else
                begin
                    tx_burst = $urandom_range(1, 12);
                    tx_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result-side backpressure: randomly chosen ready stretches and stall stretches
    always @(negedge clk)
    begin
        if (rx_run == 0)
        begin
            rx_hold = ($urandom_range(0, 2) == 0);
            rx_run  = rx_hold ? $urandom_range(1, 12) : $urandom_range(1, 40);
        end
        rx_run--;
        m_tready <= !rx_hold;
    end

    // ---------------------------------------------------------------- monitor
    always @(posedge clk)
    begin : watch
        alloc_reply_t due;
        bit           any_beat;
        any_beat = 1'b0;
        req_beat <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            next_fit_outcome(s_tuser, s_tdata[ZONE_W-1:0]);
            any_beat = 1'b1;
        end
        if (rst_n && cfg_valid && cfg_ready)
            any_beat = 1'b1;
        if (rst_n && m_tvalid && m_tready)
        begin
            any_beat = 1'b1;
            if (outcomes_due.size() == 0)
            begin
                $error("result beat with nothing due: status %0d granted_zone %0d",
                       m_tuser, m_tdata);
                fail_count++;
            end
            else
            begin
                due = outcomes_due.pop_front();
                if (m_tuser !== due.status)
                begin
                    $error("status: expected %0d, got %0d", due.status, m_tuser);
                    fail_count++;
                end
                if (m_tdata !== {{(TDATA_W-ZONE_W){1'b0}}, due.zone})
                begin
                    $error("granted_zone: expected %0d, got %0d", due.zone, m_tdata);
                    fail_count++;
                end
            end
        end
        idle_cycles = any_beat ? 0 : idle_cycles + 1;
        if (idle_cycles >= STALL_MAX)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            -> monitor_done;
    end

    // ---------------------------------------------------------------- stimulus
    task automatic send(logic mode, logic [ZONE_W-1:0] zone);
        do
            @(monitor_done);
        while (pending_reqs.size() >= 3);
        pending_reqs.push_back({mode, zone});
    endtask

    task automatic settle();
        do
            @(monitor_done);
        while (pending_reqs.size() != 0 || s_tvalid || outcomes_due.size() != 0);
    endtask

    task automatic write_reg(logic idx, logic [ZONE_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(monitor_done);
        while (!cfg_ready);
        if (idx == REG_FIRST_DATA_ZONE)
            first_zone_q = val[FIRST_W-1:0];
        else
            zone_total_q = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_range(logic [ZONE_W-1:0] first_raw, logic [ZONE_W-1:0] total);
        settle();
        write_reg(REG_FIRST_DATA_ZONE, first_raw);
        write_reg(REG_ZONE_TOTAL, total);
    endtask

    task automatic random_item(int unsigned alloc_pct);
        int unsigned       span;
        int unsigned       pick;
        bit                found;
        logic [ZONE_W-1:0] zone;
        span  = usable_span();
        found = 1'b0;
        pick  = 0;
        if ($urandom_range(0, 99) < 20)
        begin
            // stray frees: anywhere, inside the range or just past its end, or a repeat of the last free
            case ($urandom_range(0, 2))
                0:       zone = ZONE_W'($urandom_range(0, 131071));
                1:       zone = ZONE_W'(first_zone_q + $urandom_range(0, span + 4));
                default: zone = last_freed;
            endcase
            send(MODE_FREE, zone);
        end
        else if ($urandom_range(0, 99) < alloc_pct || held_bits.size() == 0)
            send(MODE_ALLOC, ZONE_W'($urandom_range(0, 131071)));
        else
        begin
            for (int t = 0; t < 4 && !found; t++)
            begin
                pick  = $urandom_range(0, held_bits.size() - 1);
                found = (held_bits[pick] < span);
            end
            if (found)
            begin
                zone = ZONE_W'(first_zone_q + held_bits[pick]);
                held_bits.delete(pick);
                last_freed = zone;
                send(MODE_FREE, zone);
            end
            else
                send(MODE_ALLOC, ZONE_W'($urandom_range(0, 131071)));
        end
    endtask

    initial
    begin
        int unsigned first_raw;
        int unsigned total;
        int unsigned alloc_pct;
        int unsigned n;
        int unsigned random_sent;
        random_sent = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // default range: sequential grants, hole left behind, double free, range edges
        send(MODE_ALLOC, '0);
        send(MODE_ALLOC, 17'h1FFFF);
        send(MODE_ALLOC, '0);
        send(MODE_FREE, 17'd1);
        send(MODE_FREE, 17'd1);
        send(MODE_FREE, 17'd65536);
        send(MODE_FREE, 17'h1FFFF);
        send(MODE_ALLOC, '0);

        // first_data_zone written with bit 16 set (dropped), both registers at maximum
        set_range(17'h1FFFF, 17'h1FFFF);
        send(MODE_ALLOC, '0);
        send(MODE_FREE, 17'd0);
        send(MODE_FREE, 17'd65535);
        send(MODE_FREE, 17'h1FFFF);

        // range wider than the map
        set_range(17'd0, 17'd131071);
        send(MODE_FREE, 17'd65536);
        send(MODE_FREE, 17'd100000);

        // empty range
        set_range(17'd0, 17'd0);
        send(MODE_ALLOC, '0);
        send(MODE_FREE, 17'd0);

        // four-zone range: start past the end, fill up, wrap around
        set_range(17'd200, 17'd204);
        send(MODE_ALLOC, '0);
        send(MODE_ALLOC, '0);
        send(MODE_ALLOC, '0);
        send(MODE_FREE, 17'd202);
        send(MODE_ALLOC, '0);
        send(MODE_FREE, 17'd200);
        send(MODE_ALLOC, '0);

        while (random_sent < RAND_ITEMS)
        begin
            first_raw = $urandom_range(0, 65535);
            case ($urandom_range(0, 19))
                0, 1:    total = $urandom_range(0, first_raw);
                2, 3, 4: total = $urandom_range(first_raw + 1, 131071);
                5:
                begin
                    first_raw = 0;
                    total     = 131071;
                end
                6:
                begin
                    first_raw = 65535;
                    total     = $urandom_range(0, 1) ? 131071 : 65536 + $urandom_range(0, 96);
                end
                default: total = first_raw + $urandom_range(1, 96);
            endcase
            // bit 16 of the first_data_zone write is ignored by the block
            if ($urandom_range(0, 3) == 0)
                first_raw = first_raw | 32'h1_0000;
            set_range(first_raw[ZONE_W-1:0], total[ZONE_W-1:0]);
            alloc_pct = $urandom_range(35, 80);
            n = $urandom_range(40, 160);
            repeat (n) random_item(alloc_pct);
            random_sent += n;
        end

        settle();
        repeat (64) @(monitor_done);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
